// ===== rtl/core/pkm_pkg.sv =====
// shared types, register codes and full-scale lookup for the peak meter
package pkm_pkg;

  localparam int LEVEL_FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic REG_SAMPLE_FORMAT = 1'b0;
  localparam logic REG_BYTE_ORDER    = 1'b1;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_U8   = 3'd1,
    FMT_S8   = 3'd2,
    FMT_U16  = 3'd3,
    FMT_S16  = 3'd4,
    FMT_U32  = 3'd5,
    FMT_S32  = 3'd6,
    FMT_F32  = 3'd7
  } fmt_t;

  // one finished block waiting for its level computation
  typedef struct packed {
    logic [31:0] peak;
    fmt_t        fmt;
  } job_t;

  function automatic logic [31:0] full_scale(input fmt_t f);
    logic [31:0] fs;
    unique case (f)
      FMT_U8:  fs = 32'd255;
      FMT_S8:  fs = 32'd127;
      FMT_U16: fs = 32'd65535;
      FMT_S16: fs = 32'd32767;
      FMT_U32: fs = 32'hffff_ffff;
      FMT_S32: fs = 32'h7fff_ffff;
      default: fs = 32'h7fff_ffff;
    endcase
    return fs;
  endfunction

endpackage

// ===== rtl/core/pkm_front.sv =====
// front end: sample decode, running peak and block-end job push
module pkm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  pkm_pkg::fmt_t        sample_format,
  input  logic                 byte_order,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          raw_sample,
  input  logic                 last_in_block,
  output logic                 push,
  output pkm_pkg::job_t        push_job,
  input  logic                 q_full
);
  import pkm_pkg::*;

  logic        s1_valid;
  logic [31:0] s1_mag;
  logic        s1_last;
  fmt_t        s1_fmt;
  logic [31:0] running_peak;

  logic [15:0] w16;
  logic [31:0] w32;
  logic [31:0] mag;
  logic        s1_adv;
  logic        s1_meter;
  logic [31:0] peak_upd;
  logic [31:0] fs;

  function automatic logic [31:0] float_mag(input logic [31:0] b);
    logic [7:0]  e;
    logic [22:0] m;
    logic [31:0] sig;
    logic [31:0] r;
    e   = b[30:23];
    m   = b[22:0];
    sig = {8'd0, 1'b1, m};
    priority if (e == 8'hff) begin
      r = (m != 23'd0) ? 32'd0 : 32'hffff_ffff;
    end else if (e == 8'd0) begin
      r = 32'd0;
    end else if (e >= 8'd128) begin
      r = 32'hffff_ffff;
    end else if (e >= 8'd119) begin
      r = sig << (e - 8'd119);
    end else if (e <= 8'd95) begin
      r = 32'd0;
    end else begin
      r = sig >> (8'd119 - e);
    end
    return r;
  endfunction

  // byte order for 16 and 32 bit words
  always_comb begin
    w16 = byte_order ? {raw_sample[7:0], raw_sample[15:8]} : raw_sample[15:0];
    w32 = byte_order ? {raw_sample[7:0], raw_sample[15:8], raw_sample[23:16],
                        raw_sample[31:24]} : raw_sample;
  end

  always_comb begin
    unique case (sample_format)
      FMT_U8:  mag = {24'd0, raw_sample[7:0]};
      FMT_S8:  mag = raw_sample[7] ? 32'(9'h100 - {1'b0, raw_sample[7:0]})
                                   : {24'd0, raw_sample[7:0]};
      FMT_U16: mag = {16'd0, w16};
      FMT_S16: mag = w16[15] ? 32'(17'h10000 - {1'b0, w16}) : {16'd0, w16};
      FMT_U32: mag = w32;
      FMT_S32: mag = w32[31] ? (32'd0 - w32) : w32;
      FMT_F32: mag = float_mag(w32);
      default: mag = 32'd0;
    endcase
  end

  // second stage: compare, clamp, push
  always_comb begin
    s1_meter = (s1_fmt != FMT_NONE);
    s1_adv   = s1_valid && !(s1_last && s1_meter && q_full);
    in_ready = !s1_valid || s1_adv;
    peak_upd = (s1_meter && (s1_mag > running_peak)) ? s1_mag : running_peak;
    fs       = full_scale(s1_fmt);
    push     = s1_adv && s1_last && s1_meter;
    push_job.peak = (peak_upd < fs) ? peak_upd : fs;
    push_job.fmt  = s1_fmt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      running_peak <= 32'd0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        running_peak <= s1_last ? 32'd0 : peak_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mag  <= mag;
      s1_last <= last_in_block;
      s1_fmt  <= sample_format;
    end
  end

endmodule

// ===== rtl/core/pkm_queue.sv =====
// short job queue between front and back
module pkm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pkm_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output pkm_pkg::job_t q_job
);
  import pkm_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entries [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_valid = (count != CW'(0));
  assign q_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/core/pkm_back.sv =====
// back end: level from the clamped peak and the output word register
module pkm_back #(
  parameter int LEVEL_FRAC_BITS = pkm_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  pkm_pkg::job_t              q_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_peak,
  output logic [LEVEL_FRAC_BITS:0]   out_level
);
  import pkm_pkg::*;

  logic [31:0]              fs;
  logic [31:0]              p;
  logic [27:0]              rep7;
  logic [31:0]              rep8;
  logic [29:0]              rep15;
  logic [31:0]              rep16;
  logic [LEVEL_FRAC_BITS:0] level;

  // every full scale is 2^k - 1, so a peak below it over the full scale is
  // the k-bit peak repeated after the binary point; the level takes its top bits
  always_comb begin
    p     = q_job.peak;
    fs    = full_scale(q_job.fmt);
    rep7  = {4{p[6:0]}};
    rep8  = {4{p[7:0]}};
    rep15 = {2{p[14:0]}};
    rep16 = {2{p[15:0]}};
    if (p == fs) begin
      level = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
    end else begin
      unique case (q_job.fmt)
        FMT_U8:  level = {1'b0, rep8[31 -: LEVEL_FRAC_BITS]};
        FMT_S8:  level = {1'b0, rep7[27 -: LEVEL_FRAC_BITS]};
        FMT_U16: level = {1'b0, rep16[31 -: LEVEL_FRAC_BITS]};
        FMT_S16: level = {1'b0, rep15[29 -: LEVEL_FRAC_BITS]};
        FMT_U32: level = {1'b0, p[31 -: LEVEL_FRAC_BITS]};
        default: level = {1'b0, p[30 -: LEVEL_FRAC_BITS]};   // s32 and float
      endcase
    end
  end

  // take a job whenever the output register is free or being emptied
  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_peak  <= p;
      out_level <= level;
    end
  end

  // level never exceeds one whole
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_level <= {1'b1, {LEVEL_FRAC_BITS{1'b0}}}))
    else $error("level above full scale");

  // silent block reads as zero level
  a_zero_peak: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_peak == 32'd0)) |-> (out_level == '0))
    else $error("nonzero level for zero peak");

  // a stalled word stays put
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_peak) && $stable(out_level)))
    else $error("output word changed while stalled");

  // a whole level needs a nonzero peak
  a_whole_peak: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_level[LEVEL_FRAC_BITS]) |-> (out_peak != 32'd0))
    else $error("full level with zero peak");

endmodule

// ===== rtl/core/audio_block_peak_meter_core.sv =====
// top level of the block peak level meter
//
// usage:
//  - s_axis carries one sample word per cycle: raw sample bytes in tdata, first
//    memory byte in bits 7:0, and tlast on the final sample of a metering block
//  - cfg_we/cfg_addr/cfg_data set the sample format (index 0) and byte order
//    (index 1); write them only while no block is in flight
//  - m_axis gives one word per block with a nonzero format: clamped peak in
//    tdata bits 31:0 and the level fraction above it
// stages and throughput:
//  - samples are taken one per cycle while s_axis_tready is high; the front
//    decodes in one stage and compares against the running peak in the next
//  - every full scale is 2^k - 1, so the level is the clamped peak's bit
//    pattern repeated, with no divider; the job queue feeds the output
//    register, one job per cycle while m_axis_tready is high
//  - while m_axis stalls, finished blocks wait in the 4-entry job queue;
//    with the queue full, s_axis_tready drops at the next block end
// reset clears the running peak, the job queue, the config registers and the
// output valid; a stalled m_axis holds its word
module audio_block_peak_meter_core #(
  parameter int LEVEL_FRAC_BITS = pkm_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [2:0]  cfg_data,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_sample [31:0]
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // peak_value [31:0], level_fraction [32+LEVEL_FRAC_BITS:32], zero pad above
  output logic [((LEVEL_FRAC_BITS + 40) / 8) * 8 - 1:0] m_axis_tdata
);
  import pkm_pkg::*;

  localparam int DATA_W = ((LEVEL_FRAC_BITS + 40) / 8) * 8;

  // config registers
  fmt_t sample_format;
  logic byte_order;

  // front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to back
  logic q_valid;
  job_t q_job;
  logic pop;

  logic [31:0]              out_peak;
  logic [LEVEL_FRAC_BITS:0] out_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_NONE;
      byte_order    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAMPLE_FORMAT: sample_format <= fmt_t'(cfg_data);
        REG_BYTE_ORDER:    byte_order    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decode and peak tracking
  pkm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_format (sample_format),
    .byte_order    (byte_order),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .raw_sample    (s_axis_tdata),
    .last_in_block (s_axis_tlast),
    .push          (push),
    .push_job      (push_job),
    .q_full        (q_full)
  );

  // finished blocks wait here for the back end
  pkm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // level and output word register
  pkm_back #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_peak  (out_peak),
    .out_level (out_level)
  );

  // pack fields low to high, zero fill to a whole byte
  assign m_axis_tdata = DATA_W'({out_level, out_peak});

endmodule

// ===== verif/tb_audio_block_peak_meter_core.sv =====
// self-checking testbench for the block peak level meter core
`timescale 1ns / 100ps

module tb_audio_block_peak_meter_core;
  import pkm_pkg::*;

  localparam int FRAC_BITS = pkm_pkg::LEVEL_FRAC_BITS_DEF;
  localparam int LEVEL_W = FRAC_BITS + 1;
  localparam int OUT_W = ((FRAC_BITS + 40) / 8) * 8;
  // settle time once every expected result is back, before touching the
  // registers or ending the run
  localparam int IDLE_SETTLE = 2 * (FRAC_BITS + 5);
  // watchdog limit on the run length, with lots of room to spare
  localparam int CYCLE_LIMIT = 400000;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SLOW
  } rx_mode_t;

  // one block result as the meter reports it
  typedef struct {
    logic [31:0]        peak;
    logic [LEVEL_W-1:0] level;
  } block_level_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_addr = REG_SAMPLE_FORMAT;
  logic [2:0]        cfg_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // raw_sample [31:0]
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // peak_value [31:0], level_fraction [48:32], zero pad above
  logic [OUT_W-1:0]  m_axis_tdata;

  // predictor state: our own copy of the config and the running peak
  fmt_t              tb_fmt = FMT_NONE;
  logic              tb_big_endian = 1'b0;
  logic [31:0]       tb_peak = '0;
  block_level_t      level_expect_q[$];

  int                mismatch_count = 0;
  int                cycle_count = 0;
  // sender burst shaping, set per test
  int                gap_max = 0;
  int                burst_left = 0;
  // receiver stall shaping
  rx_mode_t          rx_mode = RX_OPEN;
  int                stall_left = 0;

  fmt_t all_fmts[8] = '{FMT_NONE, FMT_U8, FMT_S8, FMT_U16, FMT_S16, FMT_U32,
                        FMT_S32, FMT_F32};

  audio_block_peak_meter_core #(
    .LEVEL_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // reverse the four bytes: memory order to big-endian value and back
  function automatic logic [31:0] swap_bytes32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // |f| * 2^31 truncated, saturating at all ones, NaN gives zero
  function automatic logic [31:0] float_magnitude(input logic [31:0] bits);
    logic [7:0]  expo;
    logic [22:0] man;
    logic [63:0] sig;
    int          sh;
    expo = bits[30:23];
    man  = bits[22:0];
    if (expo == 8'hff) return (man != '0) ? 32'd0 : 32'hffff_ffff;
    if (expo == 8'h00) return 32'd0;   // zero and denormals
    sig = {40'd0, 1'b1, man};
    sh  = int'(expo) - 119;
    if (sh >= 9) return 32'hffff_ffff;
    if (sh >= 0) return 32'(sig << sh);
    if (sh <= -24) return 32'd0;
    return 32'(sig >> (-sh));
  endfunction

  // unsigned magnitude of one raw sample under the current format
  function automatic logic [31:0] decode_magnitude(input logic [31:0] raw);
    logic [15:0] half;
    logic [31:0] full;
    logic [31:0] v;
    half = tb_big_endian ? {raw[7:0], raw[15:8]} : raw[15:0];
    full = tb_big_endian ? swap_bytes32(raw) : raw;
    case (tb_fmt)
      FMT_U8:  v = {24'd0, raw[7:0]};
      FMT_S8:  begin
        v = {24'd0, raw[7:0]};
        if (v[7]) v = 32'h100 - v;
      end
      FMT_U16: v = {16'd0, half};
      FMT_S16: begin
        v = {16'd0, half};
        if (v[15]) v = 32'h1_0000 - v;
      end
      FMT_U32: v = full;
      FMT_S32: v = full[31] ? 32'd0 - full : full;
      FMT_F32: v = float_magnitude(full);
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] format_ceiling(input fmt_t f);
    case (f)
      FMT_U8:  return 32'd255;
      FMT_S8:  return 32'd127;
      FMT_U16: return 32'd65535;
      FMT_S16: return 32'd32767;
      FMT_U32: return 32'hffff_ffff;
      default: return 32'h7fff_ffff;   // s32 and float
    endcase
  endfunction

  // update the running peak for one accepted word, queue the block result
  task automatic track_peak(input logic [31:0] raw, input logic last);
    logic [31:0]  mag;
    logic [31:0]  ceiling;
    logic [31:0]  clamped;
    logic [63:0]  ratio;
    block_level_t res;
    if (tb_fmt != FMT_NONE) begin
      mag = decode_magnitude(raw);
      if (mag > tb_peak) tb_peak = mag;
    end
    if (last) begin
      // format none swallows the block: no result, peak still cleared
      if (tb_fmt != FMT_NONE) begin
        ceiling   = format_ceiling(tb_fmt);
        clamped   = (tb_peak < ceiling) ? tb_peak : ceiling;
        ratio     = ({32'd0, clamped} << FRAC_BITS) / {32'd0, ceiling};
        res.peak  = clamped;
        res.level = ratio[LEVEL_W-1:0];
        level_expect_q.push_back(res);
      end
      tb_peak = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_level_word(input logic [OUT_W-1:0] word);
    logic [31:0]        got_peak;
    logic [LEVEL_W-1:0] got_level;
    block_level_t       want;
    got_peak  = word[31:0];
    got_level = word[32 +: LEVEL_W];
    if (level_expect_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word, peak %h level %h", got_peak, got_level));
    end else begin
      want = level_expect_q.pop_front();
      if (got_peak !== want.peak || got_level !== want.level)
        report_mismatch($sformatf("expected peak %h level %h, got peak %h level %h",
                                  want.peak, want.level, got_peak, got_level));
    end
  endtask

  // values seen right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_level_word(m_axis_tdata);
    // switch stall pattern at regular intervals
    if (cycle_count % 250 == 0) begin
      case ($urandom_range(0, 2))
        0:       rx_mode = RX_OPEN;
        1:       rx_mode = RX_CHOPPY;
        default: rx_mode = RX_SLOW;
      endcase
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        // long stalls now and then
        if (stall_left != 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(4, 30);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sample side
  // ---------------------------------------------------------------------------

  // send one sample word; called right after a rising edge
  task automatic send_sample(input logic [31:0] raw, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_peak(raw, last);
  endtask

  // stop sending and hold off until every block result is back
  task automatic pause_until_empty(input int settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (level_expect_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // write both registers once the meter has gone quiet
  task automatic program_meter(input fmt_t fmt, input logic big_endian);
    pause_until_empty(IDLE_SETTLE);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_SAMPLE_FORMAT;
    cfg_data <= fmt;
    @(posedge clk);
    cfg_addr <= REG_BYTE_ORDER;
    cfg_data <= {2'b00, big_endian};
    @(posedge clk);
    cfg_we <= 1'b0;
    tb_fmt        = fmt;
    tb_big_endian = big_endian;
    @(posedge clk);
  endtask

  // random sample biased toward the interesting codes of the current format
  function automatic logic [31:0] pick_sample();
    logic [31:0] r;
    logic [31:0] f;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 11))
          0:  r = 32'h0000_0000;
          1:  r = 32'hffff_ffff;
          2:  r = 32'h0000_0080;   // most negative s16/s32 big endian
          3:  r = 32'h0000_8000;   // most negative s16 little endian
          4:  r = 32'h8000_0000;
          5:  r = 32'h7fff_ffff;
          6:  r = 32'h0000_007f;
          7:  r = 32'h7f80_0000;   // +inf
          8:  r = 32'hffc0_0001;   // nan
          9:  r = 32'h3f80_0000;   // 1.0
          10: r = 32'h4f80_0000;   // 2^32
          default: r = 32'h0080_0000;   // smallest normal
        endcase
      end
      1: r = r >> $urandom_range(0, 31);
      2, 3: begin
        if (tb_fmt == FMT_F32) begin
          // exponents around the truncation and saturation edges
          f = {r[31], 8'($urandom_range(90, 140)), r[22:0]};
          r = tb_big_endian ? swap_bytes32(f) : f;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // a complete block of random samples
  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // format none straight out of reset: samples ignored, no result
  task automatic test_reset_state();
    gap_max = 0;
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
  endtask

  // full-scale, zero and most negative codes across the integer formats
  task automatic test_integer_formats();
    gap_max = 3;
    program_meter(FMT_U8, 1'b0);
    send_sample(32'hffff_ff00, 1'b0);   // upper bytes ignored
    send_sample(32'h0000_00ff, 1'b1);
    program_meter(FMT_S8, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h0000_00ff, 1'b1);
    send_sample(32'h0000_0080, 1'b1);   // -128 clamps to full scale
    program_meter(FMT_U16, 1'b1);
    send_sample(32'h0000_ff00, 1'b0);
    send_sample(32'habcd_1234, 1'b1);
    program_meter(FMT_S16, 1'b0);
    send_sample(32'h0000_8000, 1'b1);
    program_meter(FMT_U32, 1'b0);
    send_sample(32'hffff_ffff, 1'b1);
    send_sample(32'h0000_0000, 1'b1);
    program_meter(FMT_S32, 1'b1);
    send_sample(32'h0000_0080, 1'b1);
  endtask

  // one float per block: one, infinity, nan, denormal, negative, overflow
  task automatic test_float_decode();
    gap_max = 0;
    program_meter(FMT_F32, 1'b0);
    send_sample(32'h3f80_0000, 1'b1);
    send_sample(32'h7f80_0000, 1'b1);
    send_sample(32'h7fc0_0000, 1'b1);
    send_sample(32'h0000_0001, 1'b1);
    send_sample(32'hbf00_0000, 1'b1);
    send_sample(32'h4f80_0000, 1'b1);
  endtask

  // peak survives a format change inside a block; format none clears it
  task automatic test_format_switch();
    gap_max = 2;
    program_meter(FMT_S16, 1'b0);
    send_sample(32'h0000_4000, 1'b0);
    program_meter(FMT_U8, 1'b0);
    send_sample(32'h0000_0001, 1'b1);   // clamp with the new format
    send_sample(32'h0000_0050, 1'b0);
    program_meter(FMT_NONE, 1'b0);
    send_sample(32'h0000_00ff, 1'b1);
    program_meter(FMT_U8, 1'b0);
    send_sample(32'h0000_0010, 1'b1);
  endtask

  // sweep every format and byte order with random blocks
  task automatic test_random_formats();
    int phase;
    int sent;
    int len;
    phase = 0;
    foreach (all_fmts[k]) begin
      for (int order = 0; order < 2; order++) begin
        program_meter(all_fmts[k], 1'(order));
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        sent = 0;
        while (sent < 16) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 5);
          send_block(len);
          sent += len;
          // hold off mid-phase once until everything is back
          if (phase == 5 && sent >= 8 && sent - len < 8) pause_until_empty(0);
        end
        phase++;
      end
    end
  endtask

  // one-sample blocks back to back to fill the job queue
  task automatic test_short_blocks();
    gap_max = 0;
    program_meter(all_fmts[$urandom_range(1, 7)], 1'($urandom_range(0, 1)));
    for (int i = 0; i < 40; i++) send_block(1);
    gap_max = 2;
    program_meter(all_fmts[$urandom_range(1, 7)], 1'($urandom_range(0, 1)));
    for (int i = 0; i < 40; i++) send_block(1);
  endtask

  // a few long blocks in the wide formats
  task automatic test_long_blocks();
    gap_max = 4;
    program_meter(FMT_S32, 1'b0);
    send_block(25);
    send_block(20);
    program_meter(FMT_F32, 1'b1);
    send_block(25);
    send_block(15);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_integer_formats();
    test_float_decode();
    test_format_switch();
    test_random_formats();
    test_short_blocks();
    test_long_blocks();
    pause_until_empty(IDLE_SETTLE);
    if (level_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", level_expect_q.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
